// ===== design/tbf_pkg.sv =====
// ----------------------------------------------------------------------------
// tbf_pkg
// Shared types, constants and address helpers of the tile background fetcher.
// ----------------------------------------------------------------------------
package tbf_pkg;

    // Video memory depth; a power of two so address wrap is a truncation.
    localparam int VRAM_DEPTH = 8192;
    localparam int VRAM_AW    = $clog2(VRAM_DEPTH);

    localparam int PIX_PER_PUSH = 8;
    localparam int PIX_CNT_W    = $clog2(PIX_PER_PUSH + 1);

    localparam logic [4:0] FIFO_PUSH_MAX = 5'd8;   // push waits above this level
    localparam logic [4:0] MAP_COL_MASK  = 5'h1f;
    localparam int         TILE_SHIFT    = 4;      // 16 bytes per tile

    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BG_PALETTE  = 2'd0,
        CFG_DATA_BASE   = 2'd1,
        CFG_SIGNED_IDS  = 2'd2,
        CFG_WIN_MAP     = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        PH_ID    = 5'b00001,
        PH_LOW   = 5'b00010,
        PH_HIGH  = 5'b00100,
        PH_SLEEP = 5'b01000,
        PH_PUSH  = 5'b10000
    } t_phase;

    typedef enum logic [2:0] {
        RD_TILE = 3'b001,
        RD_LOW  = 3'b010,
        RD_HIGH = 3'b100
    } t_rd_dest;

    // Request from the fetcher to the pixel output stage.
    typedef struct packed {
        logic       valid;
        logic       window;   // single window-switch beat instead of 8 pixels
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] pal;
    } t_push_req;

    // 13-bit offset into a video memory address (wraps modulo depth).
    function automatic logic [VRAM_AW-1:0] addr13(input logic [12:0] a);
        logic [VRAM_AW+12:0] w;
        w = {{VRAM_AW{1'b0}}, a};
        return w[VRAM_AW-1:0];
    endfunction

    // Tile id times 16, optionally sign-extended, wrapped to an address.
    function automatic logic [VRAM_AW-1:0] tile_offset(input logic [7:0] id,
                                                       input logic       sgn);
        logic [8:0]          ext;
        logic [VRAM_AW+12:0] w;
        ext = {sgn & id[7], id};
        w   = {{VRAM_AW{ext[8]}}, ext, {TILE_SHIFT{1'b0}}};
        return w[VRAM_AW-1:0];
    endfunction

endpackage

// ===== design/tile_background_fetcher_top.sv =====
// ----------------------------------------------------------------------------
// tile_background_fetcher_top
// Background tile fetcher: video memory, five-phase fetch sequencer, pixel push.
//
// channel   dir  handshake             payload
// s_axis    in   tvalid/tready         tuser: command; tdata: start/write/tick
// m_axis    out  tvalid/tready         tuser: kind; tdata: color, palette; tlast
// cfg       in   i_cfg_we              i_cfg_index, i_cfg_data
//
// One item per cycle is taken; an acting tick issues at most one video memory
// read, whose byte reaches the tile or plane register via the RAM register.
// A push occupies the serializer for 8 output beats; input is held until its
// final beat moves into the output register. A window beat takes one.
// Reset is synchronous, active low; video memory is not cleared.
// ----------------------------------------------------------------------------
module tile_background_fetcher_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config
    input  logic                           i_cfg_we,
    input  logic [tbf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tbf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [12:0] map_base, [15:13] fine_row_in, [23:16] start_column,
    // [36:24] mem_address, [44:37] mem_data, [45] window_request,
    // [48:46] window_row, [56:49] window_column, [61:57] fifo_level, [63:62] 0
    input  logic [63:0]                    s_axis_tdata,
    input  logic [1:0]                     s_axis_tuser,   // [1:0] command
    // output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [15:0]                    m_axis_tdata,   // [1:0] color, [9:2] palette, [15:10] 0
    output logic                           m_axis_tuser,   // [0] kind
    output logic                           m_axis_tlast
);

    localparam int AW = tbf_pkg::VRAM_AW;

    // input fields
    logic [12:0] f_map_base;
    logic [2:0]  f_fine_row;
    logic [7:0]  f_start_col;
    logic [12:0] f_mem_addr;
    logic [7:0]  f_mem_data;
    logic        f_win_req;
    logic [2:0]  f_win_row;
    logic [7:0]  f_win_col;
    logic [4:0]  f_fifo_lvl;
    tbf_pkg::t_cmd cmd;

    assign f_map_base  = s_axis_tdata[12:0];
    assign f_fine_row  = s_axis_tdata[15:13];
    assign f_start_col = s_axis_tdata[23:16];
    assign f_mem_addr  = s_axis_tdata[36:24];
    assign f_mem_data  = s_axis_tdata[44:37];
    assign f_win_req   = s_axis_tdata[45];
    assign f_win_row   = s_axis_tdata[48:46];
    assign f_win_col   = s_axis_tdata[56:49];
    assign f_fifo_lvl  = s_axis_tdata[61:57];
    assign cmd         = tbf_pkg::t_cmd'(s_axis_tuser);

    // config registers
    logic [7:0]  r_bg_pal;
    logic [12:0] r_data_base;
    logic        r_signed_ids;
    logic [12:0] r_win_map;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg_pal     <= '0;
            r_data_base  <= '0;
            r_signed_ids <= 1'b0;
            r_win_map    <= '0;
        end else if (i_cfg_we) begin
            unique case (tbf_pkg::t_cfg_idx'(i_cfg_index))
                tbf_pkg::CFG_BG_PALETTE: r_bg_pal     <= i_cfg_data[7:0];
                tbf_pkg::CFG_DATA_BASE:  r_data_base  <= i_cfg_data;
                tbf_pkg::CFG_SIGNED_IDS: r_signed_ids <= i_cfg_data[0];
                tbf_pkg::CFG_WIN_MAP:    r_win_map    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // fetcher state
    logic            r_toggle,   n_toggle;
    tbf_pkg::t_phase r_phase,    n_phase;
    logic [12:0]     r_row_base, n_row_base;
    logic [2:0]      r_fine_row, n_fine_row;
    logic [7:0]      r_col,      n_col;
    logic [7:0]      r_tile;
    logic [7:0]      r_low;
    logic [7:0]      r_high;
    logic              r_rd_valid, n_rd_valid;
    tbf_pkg::t_rd_dest r_rd_dest,  n_rd_dest;

    logic            accept;
    logic            acting;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   plane_addr;
    logic [7:0]      rd_data;
    logic            pix_ready;
    tbf_pkg::t_push_req req;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign acting = accept && (cmd == tbf_pkg::CMD_TICK) && r_toggle;
    assign s_axis_tready = pix_ready;

    assign plane_addr = tbf_pkg::addr13(r_data_base)
                      + tbf_pkg::tile_offset(r_tile, r_signed_ids)
                      + tbf_pkg::addr13({9'd0, r_fine_row, 1'b0});

    always_comb begin
        n_toggle   = r_toggle;
        n_phase    = r_phase;
        n_row_base = r_row_base;
        n_fine_row = r_fine_row;
        n_col      = r_col;
        n_rd_valid = 1'b0;
        n_rd_dest  = r_rd_dest;
        rd_en      = 1'b0;
        rd_addr    = plane_addr;
        req        = '0;

        if (accept && cmd == tbf_pkg::CMD_START) begin
            n_row_base = f_map_base;
            n_fine_row = f_fine_row;
            n_col      = f_start_col;
            n_phase    = tbf_pkg::PH_ID;
        end else if (accept && cmd == tbf_pkg::CMD_TICK) begin
            n_toggle = !r_toggle;
        end

        if (acting) begin
            if (f_win_req) begin
                n_row_base = r_win_map;
                n_fine_row = f_win_row;
                n_col      = f_win_col;
                req.valid  = 1'b1;
                req.window = 1'b1;
            end
            if (f_win_req && r_phase != tbf_pkg::PH_ID) begin
                n_phase = tbf_pkg::PH_ID;
            end else begin
                unique case (r_phase)
                    tbf_pkg::PH_ID: begin
                        rd_en      = 1'b1;
                        rd_addr    = tbf_pkg::addr13(n_row_base)
                                   + tbf_pkg::addr13({8'd0, n_col[4:0] & tbf_pkg::MAP_COL_MASK});
                        n_rd_valid = 1'b1;
                        n_rd_dest  = tbf_pkg::RD_TILE;
                        n_phase    = tbf_pkg::PH_LOW;
                    end
                    tbf_pkg::PH_LOW: begin
                        rd_en      = 1'b1;
                        n_rd_valid = 1'b1;
                        n_rd_dest  = tbf_pkg::RD_LOW;
                        n_phase    = tbf_pkg::PH_HIGH;
                    end
                    tbf_pkg::PH_HIGH: begin
                        rd_en      = 1'b1;
                        rd_addr    = plane_addr + AW'(1);
                        n_rd_valid = 1'b1;
                        n_rd_dest  = tbf_pkg::RD_HIGH;
                        n_phase    = tbf_pkg::PH_SLEEP;
                    end
                    tbf_pkg::PH_SLEEP: begin
                        n_phase = tbf_pkg::PH_PUSH;
                    end
                    tbf_pkg::PH_PUSH: begin
                        if (f_fifo_lvl <= tbf_pkg::FIFO_PUSH_MAX) begin
                            req.valid  = 1'b1;
                            req.window = 1'b0;
                            req.lo     = r_low;
                            req.hi     = r_high;
                            req.pal    = r_bg_pal;
                            n_col      = r_col + 8'd1;
                            n_phase    = tbf_pkg::PH_ID;
                        end
                    end
                    default: n_phase = tbf_pkg::PH_ID;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_toggle   <= 1'b0;
            r_phase    <= tbf_pkg::PH_ID;
            r_row_base <= '0;
            r_fine_row <= '0;
            r_col      <= '0;
            r_rd_valid <= 1'b0;
            r_rd_dest  <= tbf_pkg::RD_TILE;
        end else begin
            r_toggle   <= n_toggle;
            r_phase    <= n_phase;
            r_row_base <= n_row_base;
            r_fine_row <= n_fine_row;
            r_col      <= n_col;
            r_rd_valid <= n_rd_valid;
            r_rd_dest  <= n_rd_dest;
        end
    end

    // read data returns in the cycle after issue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile <= '0;
            r_low  <= '0;
            r_high <= '0;
        end else if (r_rd_valid) begin
            unique case (r_rd_dest)
                tbf_pkg::RD_TILE: r_tile <= rd_data;
                tbf_pkg::RD_LOW:  r_low  <= rd_data;
                tbf_pkg::RD_HIGH: r_high <= rd_data;
                default: ;
            endcase
        end
    end

    tbf_ram #(
        .WIDTH (8),
        .DEPTH (tbf_pkg::VRAM_DEPTH)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (accept && cmd == tbf_pkg::CMD_WRITE),
        .i_waddr (tbf_pkg::addr13(f_mem_addr)),
        .i_wdata (f_mem_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    logic [1:0] out_color;
    logic [7:0] out_pal;

    tbf_pix_out u_pix_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .o_ready    (pix_ready),
        .i_m_tready (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_kind     (m_axis_tuser),
        .o_color    (out_color),
        .o_palette  (out_pal),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, out_pal, out_color};

endmodule

// ===== design/tbf_ram.sv =====
// ----------------------------------------------------------------------------
// tbf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/tbf_pix_out.sv =====
// ----------------------------------------------------------------------------
// tbf_pix_out
// Pixel serializer plus output register: 8 beats, MSB first, per push; 1 if window.
// ----------------------------------------------------------------------------
module tbf_pix_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tbf_pkg::t_push_req i_req,
    output logic              o_ready,
    input  logic              i_m_tready,
    output logic              o_valid,
    output logic              o_kind,
    output logic [1:0]        o_color,
    output logic [7:0]        o_palette,
    output logic              o_last
);

    logic [tbf_pkg::PIX_CNT_W-1:0] r_cnt;
    logic                          r_win;
    logic [7:0]                    r_lo;
    logic [7:0]                    r_hi;
    logic [7:0]                    r_pal;

    logic       r_ov;
    logic       r_okind;
    logic [1:0] r_ocolor;
    logic [7:0] r_opal;
    logic       r_olast;

    logic out_free;
    logic move;

    assign out_free = !r_ov || i_m_tready;
    assign move     = (r_cnt != '0) && out_free;
    // take a new push once the serializer is empty or sends its final beat now
    assign o_ready  = (r_cnt == '0) ||
                      ((r_cnt == tbf_pkg::PIX_CNT_W'(1)) && out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.valid) begin
            r_cnt <= i_req.window ? tbf_pkg::PIX_CNT_W'(1)
                                  : tbf_pkg::PIX_CNT_W'(tbf_pkg::PIX_PER_PUSH);
        end else if (move) begin
            r_cnt <= r_cnt - tbf_pkg::PIX_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_win <= i_req.window;
            r_lo  <= i_req.lo;
            r_hi  <= i_req.hi;
            r_pal <= i_req.pal;
        end else if (move) begin
            r_lo <= {r_lo[6:0], 1'b0};
            r_hi <= {r_hi[6:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (move) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_okind  <= r_win;
            r_ocolor <= {r_hi[7], r_lo[7]};
            r_opal   <= r_pal;
            r_olast  <= !r_win && (r_cnt == tbf_pkg::PIX_CNT_W'(1));
        end
    end

    assign o_valid   = r_ov;
    assign o_kind    = r_okind;
    assign o_color   = r_ocolor;
    assign o_palette = r_opal;
    assign o_last    = r_olast;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tile background fetcher. A fetch that would read
// a byte of video memory never written is preceded by a write of random data
// to that byte, so no fetch ever reads an unwritten byte. Directed corners
// come first: wrapped map and data addresses, signed tile ids, a push held off
// by a full FIFO, window switches in and out of the tile id phase, and an
// unused command. Random traffic follows under four handshake idling
// profiles. A shadow fetcher predicts every output beat, and each beat is
// compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int MAX_GAP       = 64;
    localparam int RANDOM_ITEMS  = 16;

    // one input beat, unpacked
    typedef struct {
        tbf_pkg::t_cmd cmd;
        logic [12:0]   map_base;
        logic [2:0]    fine_row;
        logic [7:0]    start_col;
        logic [12:0]   mem_addr;
        logic [7:0]    mem_data;
        logic          win_req;
        logic [2:0]    win_row;
        logic [7:0]    win_col;
        logic [4:0]    fifo_level;
    } t_fetch_item;

    typedef struct packed {
        logic       kind;
        logic [1:0] color;
        logic [7:0] palette;
        logic       last;
    } t_pix_beat;

    logic                           i_clk;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_we      = 1'b0;
    tbf_pkg::t_cfg_idx              i_cfg_index   = tbf_pkg::CFG_BG_PALETTE;
    logic [tbf_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [63:0]                    s_axis_tdata  = '0;
    tbf_pkg::t_cmd                  s_axis_tuser  = tbf_pkg::CMD_TICK;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [15:0]                    m_axis_tdata;
    logic                           m_axis_tuser;
    logic                           m_axis_tlast;

    tile_background_fetcher_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // shadow fetcher state
    logic [7:0]      vram_shadow  [0:tbf_pkg::VRAM_DEPTH-1];
    logic            vram_written [0:tbf_pkg::VRAM_DEPTH-1];
    logic            half_tick;
    tbf_pkg::t_phase fetch_phase_q;
    logic [12:0]     row_base;
    logic [2:0]      fine_row;
    logic [7:0]      tile_col;
    logic [7:0]      tile_id;
    logic [7:0]      low_bits;
    logic [7:0]      high_bits;
    logic [7:0]      shadow_palette;
    logic [12:0]     shadow_data_base;
    logic            shadow_signed;
    logic [12:0]     shadow_win_base;

    t_pix_beat pending_pixel_beats [$];
    t_pix_beat head_beat;

    int tx_idle_pct;
    int rx_stall_pct;
    int err_count;
    int cycle_count;
    int beats_sent;
    int vram_writes;
    int beats_predicted;
    int pixel_beats;
    int window_beats;
    int full_fifo_waits;
    int cfg_settings;
    int beats_checked;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);

    // output checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixel_beats.size() == 0) begin
                $error("unexpected output beat: kind=%0d color=%0d palette=%0h last=%0d",
                       m_axis_tuser, m_axis_tdata[1:0], m_axis_tdata[9:2], m_axis_tlast);
                err_count++;
            end else begin
                head_beat = pending_pixel_beats.pop_front();
                beats_checked++;
                if (m_axis_tuser !== head_beat.kind) begin
                    $error("kind: expected %0d, got %0d", head_beat.kind, m_axis_tuser);
                    err_count++;
                end
                if (m_axis_tdata[1:0] !== head_beat.color) begin
                    $error("color: expected %0d, got %0d", head_beat.color, m_axis_tdata[1:0]);
                    err_count++;
                end
                if (m_axis_tdata[9:2] !== head_beat.palette) begin
                    $error("palette: expected %0h, got %0h", head_beat.palette,
                           m_axis_tdata[9:2]);
                    err_count++;
                end
                if (m_axis_tlast !== head_beat.last) begin
                    $error("last: expected %0d, got %0d", head_beat.last, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    function automatic logic [12:0] tile_data_addr(input logic plane_sel);
        logic [12:0] id_ext;
        id_ext = {{5{shadow_signed & tile_id[7]}}, tile_id};
        return shadow_data_base + (id_ext << tbf_pkg::TILE_SHIFT)
             + {9'd0, fine_row, plane_sel};
    endfunction

    // Address this beat fetches from video memory; returns 0 when it fetches nothing.
    function automatic logic fetch_address(input t_fetch_item it,
                                           output logic [12:0] addr);
        logic [12:0] base;
        logic [7:0]  col;
        addr = '0;
        if (it.cmd != tbf_pkg::CMD_TICK || !half_tick)
            return 1'b0;
        if (it.win_req && fetch_phase_q != tbf_pkg::PH_ID)
            return 1'b0;
        base = it.win_req ? shadow_win_base : row_base;
        col  = it.win_req ? it.win_col : tile_col;
        case (fetch_phase_q)
            tbf_pkg::PH_ID: begin
                addr = base + {8'd0, col[4:0]};
                return 1'b1;
            end
            tbf_pkg::PH_LOW: begin
                addr = tile_data_addr(1'b0);
                return 1'b1;
            end
            tbf_pkg::PH_HIGH: begin
                addr = tile_data_addr(1'b1);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void predict_fetcher_beats(input t_fetch_item it);
        logic [12:0] tile_map_addr;
        t_pix_beat   b;
        case (it.cmd)
            tbf_pkg::CMD_START: begin
                row_base      = it.map_base;
                fine_row      = it.fine_row;
                tile_col      = it.start_col;
                fetch_phase_q = tbf_pkg::PH_ID;
            end
            tbf_pkg::CMD_WRITE: begin
                vram_shadow[it.mem_addr]  = it.mem_data;
                vram_written[it.mem_addr] = 1'b1;
            end
            tbf_pkg::CMD_TICK: begin
                if (!half_tick) begin
                    half_tick = 1'b1;
                    return;
                end
                half_tick = 1'b0;
                if (it.win_req) begin
                    row_base = shadow_win_base;
                    fine_row = it.win_row;
                    tile_col = it.win_col;
                    b        = '0;
                    b.kind   = 1'b1;
                    pending_pixel_beats.push_back(b);
                    beats_predicted++;
                    window_beats++;
                    // outside the tile id phase the switch only restarts the fetch
                    if (fetch_phase_q != tbf_pkg::PH_ID) begin
                        fetch_phase_q = tbf_pkg::PH_ID;
                        return;
                    end
                end
                case (fetch_phase_q)
                    tbf_pkg::PH_ID: begin
                        tile_map_addr = row_base + {8'd0, tile_col[4:0]};
                        tile_id       = vram_shadow[tile_map_addr];
                        fetch_phase_q = tbf_pkg::PH_LOW;
                    end
                    tbf_pkg::PH_LOW: begin
                        low_bits      = vram_shadow[tile_data_addr(1'b0)];
                        fetch_phase_q = tbf_pkg::PH_HIGH;
                    end
                    tbf_pkg::PH_HIGH: begin
                        high_bits     = vram_shadow[tile_data_addr(1'b1)];
                        fetch_phase_q = tbf_pkg::PH_SLEEP;
                    end
                    tbf_pkg::PH_SLEEP: fetch_phase_q = tbf_pkg::PH_PUSH;
                    tbf_pkg::PH_PUSH: begin
                        if (it.fifo_level > tbf_pkg::FIFO_PUSH_MAX) begin
                            full_fifo_waits++;
                        end else begin
                            for (int k = 7; k >= 0; k--) begin
                                b.kind    = 1'b0;
                                b.color   = {high_bits[k], low_bits[k]};
                                b.palette = shadow_palette;
                                b.last    = (k == 0);
                                pending_pixel_beats.push_back(b);
                            end
                            beats_predicted += tbf_pkg::PIX_PER_PUSH;
                            pixel_beats     += tbf_pkg::PIX_PER_PUSH;
                            tile_col         = tile_col + 8'd1;
                            fetch_phase_q    = tbf_pkg::PH_ID;
                        end
                    end
                    default: fetch_phase_q = tbf_pkg::PH_ID;
                endcase
            end
            default: ;  // unused command: nothing happens
        endcase
    endfunction

    function automatic t_fetch_item random_item();
        t_fetch_item it;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 78)      it.cmd = tbf_pkg::CMD_TICK;
        else if (r < 88) it.cmd = tbf_pkg::CMD_WRITE;
        else if (r < 97) it.cmd = tbf_pkg::CMD_START;
        else             it.cmd = tbf_pkg::CMD_NOP;
        it.map_base   = 13'($urandom_range(0, 8191));
        it.fine_row   = 3'($urandom_range(0, 7));
        it.start_col  = 8'($urandom_range(0, 255));
        it.mem_addr   = 13'($urandom_range(0, 8191));
        it.mem_data   = 8'($urandom_range(0, 255));
        it.win_req    = ($urandom_range(0, 99) < 6);
        it.win_row    = 3'($urandom_range(0, 7));
        it.win_col    = 8'($urandom_range(0, 255));
        it.fifo_level = ($urandom_range(0, 99) < 80) ? 5'($urandom_range(0, 8))
                                                      : 5'($urandom_range(9, 16));
        return it;
    endfunction

    function automatic t_fetch_item tick_item(input logic win, input logic [4:0] lvl);
        t_fetch_item it;
        it            = random_item();
        it.cmd        = tbf_pkg::CMD_TICK;
        it.win_req    = win;
        it.fifo_level = lvl;
        return it;
    endfunction

    // Leaves tvalid high on return so back-to-back beats need no extra step.
    task automatic drive_item(input t_fetch_item it);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.cmd;
        s_axis_tdata  <= {2'b00, it.fifo_level, it.win_col, it.win_row, it.win_req,
                          it.mem_data, it.mem_addr, it.start_col, it.fine_row,
                          it.map_base};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_fetcher_beats(it);
        beats_sent++;
        if (it.cmd == tbf_pkg::CMD_WRITE)
            vram_writes++;
    endtask

    task automatic send_item(input t_fetch_item it);
        t_fetch_item fill;
        logic [12:0] rd_addr;
        // a fetch from a byte never written gets that byte written first
        if (fetch_address(it, rd_addr) && !vram_written[rd_addr]) begin
            fill          = random_item();
            fill.cmd      = tbf_pkg::CMD_WRITE;
            fill.mem_addr = rd_addr;
            drive_item(fill);
        end
        drive_item(it);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_pixel_beats.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write_all(input logic [7:0] pal, input logic [12:0] base,
                                 input logic sgn, input logic [12:0] win);
        tbf_pkg::t_cfg_idx idx  [4];
        logic [12:0]       vals [4];
        idx  = '{tbf_pkg::CFG_BG_PALETTE, tbf_pkg::CFG_DATA_BASE,
                 tbf_pkg::CFG_SIGNED_IDS, tbf_pkg::CFG_WIN_MAP};
        vals = '{{5'd0, pal}, base, {12'd0, sgn}, win};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            case (idx[k])
                tbf_pkg::CFG_BG_PALETTE: shadow_palette   = vals[k][7:0];
                tbf_pkg::CFG_DATA_BASE:  shadow_data_base = vals[k];
                tbf_pkg::CFG_SIGNED_IDS: shadow_signed    = vals[k][0];
                tbf_pkg::CFG_WIN_MAP:    shadow_win_base  = vals[k];
                default: ;
            endcase
        end
        i_cfg_we <= 1'b0;
        cfg_settings++;
    endtask

    task automatic test_directed_corners();
        t_fetch_item it;
        cfg_write_all(8'hff, 13'h1fff, 1'b1, 13'h1fff);
        // top map base plus column 31 wraps to the bottom of memory
        it           = random_item();
        it.cmd       = tbf_pkg::CMD_START;
        it.map_base  = 13'h1fff;
        it.fine_row  = 3'd7;
        it.start_col = 8'hff;
        send_item(it);
        it.cmd = tbf_pkg::CMD_NOP;
        send_item(it);
        // id 0x80 at the wrapped map entry reads as -128 in signed mode
        it.cmd      = tbf_pkg::CMD_WRITE;
        it.mem_addr = 13'd30;
        it.mem_data = 8'h80;
        send_item(it);
        for (int k = 0; k < 8; k++)
            send_item(tick_item(1'b0, 5'd0));
        // push held off by a full FIFO, then released at the threshold
        repeat (2) send_item(tick_item(1'b0, 5'd16));
        repeat (2) send_item(tick_item(1'b0, 5'd9));
        repeat (2) send_item(tick_item(1'b0, 5'd8));
        // window switch in the tile id phase (first request lands on an idle tick)
        repeat (2) send_item(tick_item(1'b1, 5'd0));
        repeat (2) send_item(tick_item(1'b0, 5'd0));
        // window switch from the high plane phase
        send_item(tick_item(1'b0, 5'd0));
        send_item(tick_item(1'b1, 5'd0));
        settle();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                       input logic zero_cfg);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        if (zero_cfg)
            cfg_write_all(8'h00, 13'h0000, 1'b0, 13'h0000);
        else
            cfg_write_all(8'($urandom_range(0, 255)), 13'($urandom_range(0, 8191)),
                          1'($urandom_range(0, 1)), 13'($urandom_range(0, 8191)));
        for (int k = 0; k < RANDOM_ITEMS; k++)
            send_item(random_item());
        settle();
    endtask

    initial begin
        tx_idle_pct      = 0;
        rx_stall_pct     = 0;
        err_count        = 0;
        cycle_count      = 0;
        beats_sent       = 0;
        vram_writes      = 0;
        beats_predicted  = 0;
        pixel_beats      = 0;
        window_beats     = 0;
        full_fifo_waits  = 0;
        cfg_settings     = 0;
        beats_checked    = 0;
        half_tick        = 1'b0;
        fetch_phase_q    = tbf_pkg::PH_ID;
        row_base         = '0;
        fine_row         = '0;
        tile_col         = '0;
        tile_id          = '0;
        low_bits         = '0;
        high_bits        = '0;
        shadow_palette   = '0;
        shadow_data_base = '0;
        shadow_signed    = 1'b0;
        shadow_win_base  = '0;
        for (int a = 0; a < tbf_pkg::VRAM_DEPTH; a++)
            vram_written[a] = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_random_traffic(0, 0, 1'b0);
        test_random_traffic(86, 0, 1'b1);
        test_random_traffic(0, 86, 1'b0);
        test_random_traffic(9, 9, 1'b0);

        $display("Sent %0d input beats (%0d memory writes) over %0d register settings",
                 beats_sent, vram_writes, cfg_settings);
        $display("Checked %0d output beats: %0d pixels, %0d window; %0d full-FIFO waits",
                 beats_checked, pixel_beats, window_beats, full_fifo_waits);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", err_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
